// ===== hw/rtl/dtqd_pkg.sv =====
package dtqd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_LOOK,
      ST_ADD,
      ST_DONE,
      ST_HEAD
   } state_type;

   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_TICK = 2'd1,
      REQ_DONE = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   localparam logic [3:0] ST_QUEUED       = 4'd0;
   localparam logic [3:0] ST_DUPLICATE    = 4'd1;
   localparam logic [3:0] ST_OVERFLOW     = 4'd2;
   localparam logic [3:0] ST_DISPATCHED   = 4'd3;
   localparam logic [3:0] ST_LIMIT        = 4'd4;
   localparam logic [3:0] ST_EMPTY        = 4'd5;
   localparam logic [3:0] ST_HEAD_BUSY    = 4'd6;
   localparam logic [3:0] ST_POOL_REFUSED = 4'd7;
   localparam logic [3:0] ST_REMOVED      = 4'd8;
   localparam logic [3:0] ST_UNKNOWN      = 4'd9;

   localparam logic [3:0] MAX_RUN_RESET = 4'd5;
   localparam int FIELD_TAG_BITS = 16;

   // shift: take the neighbour's tag; load: take the broadcast tag
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/dedup_task_queue_dispatcher.sv =====
// Add and done: ST_LOOK compares, ST_ADD or ST_DONE decides and emits the result.
// Tick: a queue head passes ST_TICK (limit check), ST_LOOK (cell compare), ST_HEAD
//   (decide), one result per head; a limit or empty-queue tick answers in ST_TICK.
// The compare in every queue and running-set cell is registered, which sets the pace.
// Reset (synchronous): queue and running set empty, max_running = 5, no result.
// The receiver cannot stall; each result is shown for one cycle with rsp_valid.
module dedup_task_queue_dispatcher
   import dtqd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int RUN_SLOTS   = 8,
   parameter int TAG_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_task_tag,
   input  logic [3:0]  req_pool_accepts,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_result_tag,
   output logic [3:0]  rsp_running_count,
   output logic [4:0]  rsp_queued_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int TW = (TAG_BITS < FIELD_TAG_BITS) ? TAG_BITS : FIELD_TAG_BITS;
   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW = $clog2(RUN_SLOTS + 1);
   localparam int LW = (CW > 4) ? CW : 4;

   state_type     state_ff, state_in;
   req_kind_type  kind_ff;
   logic [TW-1:0] key_ff;
   logic [3:0]    accepts_ff;
   logic [3:0]    disp_ff;
   logic [QW-1:0] fill_ff, fill_in;
   logic [CW-1:0] run_cnt_ff, run_cnt_in;
   logic [3:0]    max_run_ff;

   logic          rsp_valid_ff;
   logic [3:0]    rsp_status_ff;
   logic [TW-1:0] rsp_tag_ff;
   logic [3:0]    rsp_run_ff;
   logic [4:0]    rsp_q_ff;
   logic          rsp_last_ff;

   logic [TW-1:0] q_tag [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] q_match;
   logic [TW-1:0] r_tag [RUN_SLOTS];
   logic [RUN_SLOTS:0] r_hit;

   logic          q_hit, r_any, q_full;
   logic          over_limit, last_disp;
   logic [LW-1:0] limit, max_lw, slots_lw, cnt_lw;
   logic [QW-1:0] push_pos;

   logic          q_pop, q_push, r_ins, r_rm, key_head, emit, emit_last, disp_inc;
   logic [3:0]    emit_status;
   logic [TW-1:0] emit_tag;

   // configuration port
   logic csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {28'd0, max_run_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= MAX_RUN_RESET;
      end else if (csr_wr) begin
         max_run_ff <= pwdata[3:0];
      end
   end

   // limit and status terms
   always_comb begin
      max_lw     = LW'(max_run_ff);
      slots_lw   = LW'(RUN_SLOTS);
      limit      = (max_lw < slots_lw) ? max_lw : slots_lw;
      cnt_lw     = LW'(run_cnt_ff);
      over_limit = cnt_lw >= limit;
      last_disp  = (cnt_lw + LW'(1)) >= limit;
      q_hit      = |q_match;
      r_any      = r_hit[RUN_SLOTS];
      q_full     = fill_ff >= QW'(QUEUE_DEPTH);
      push_pos   = q_pop ? (fill_ff - QW'(1)) : fill_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_kind_type'(req_type))
                  REQ_TICK: state_in = ST_TICK;
                  REQ_ADD,
                  REQ_DONE: state_in = ST_LOOK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (over_limit || (fill_ff == '0)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            unique case (kind_ff)
               REQ_ADD:  state_in = ST_ADD;
               REQ_DONE: state_in = ST_DONE;
               default:  state_in = ST_HEAD;
            endcase
         end
         ST_ADD:  state_in = ST_IDLE;
         ST_DONE: state_in = ST_IDLE;
         ST_HEAD: begin
            if (r_any || (disp_ff >= accepts_ff) || last_disp) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_TICK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      q_pop       = 1'b0;
      q_push      = 1'b0;
      r_ins       = 1'b0;
      r_rm        = 1'b0;
      key_head    = 1'b0;
      disp_inc    = 1'b0;
      emit        = 1'b0;
      emit_last   = 1'b1;
      emit_status = ST_QUEUED;
      emit_tag    = key_ff;
      unique case (state_ff)
         ST_TICK: begin
            if (over_limit) begin
               emit        = 1'b1;
               emit_status = ST_LIMIT;
               emit_tag    = '0;
            end else if (fill_ff == '0) begin
               emit        = 1'b1;
               emit_status = ST_EMPTY;
               emit_tag    = '0;
            end else begin
               key_head = 1'b1;
            end
         end
         ST_ADD: begin
            emit = 1'b1;
            if (q_hit) begin
               emit_status = ST_DUPLICATE;
            end else if (q_full) begin
               emit_status = ST_OVERFLOW;
            end else begin
               q_push      = 1'b1;
               emit_status = ST_QUEUED;
            end
         end
         ST_DONE: begin
            emit = 1'b1;
            if (r_any) begin
               r_rm        = 1'b1;
               emit_status = ST_REMOVED;
            end else begin
               emit_status = ST_UNKNOWN;
            end
         end
         ST_HEAD: begin
            emit  = 1'b1;
            q_pop = 1'b1;
            if (r_any) begin
               q_push      = 1'b1;
               emit_status = ST_HEAD_BUSY;
            end else if (disp_ff >= accepts_ff) begin
               q_push      = 1'b1;
               emit_status = ST_POOL_REFUSED;
            end else begin
               r_ins       = 1'b1;
               disp_inc    = 1'b1;
               emit_status = ST_DISPATCHED;
               emit_last   = last_disp;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (q_push && !q_pop) begin
         fill_in = fill_ff + QW'(1);
      end else if (q_pop && !q_push) begin
         fill_in = fill_ff - QW'(1);
      end
      run_cnt_in = run_cnt_ff;
      if (r_ins) begin
         run_cnt_in = run_cnt_ff + CW'(1);
      end else if (r_rm) begin
         run_cnt_in = run_cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         run_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         run_cnt_ff   <= run_cnt_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff    <= req_kind_type'(req_type);
         key_ff     <= req_task_tag[TW-1:0];
         accepts_ff <= req_pool_accepts;
         disp_ff    <= '0;
      end else begin
         if (key_head) begin
            key_ff <= q_tag[0];
         end
         if (disp_inc) begin
            disp_ff <= disp_ff + 4'd1;
         end
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_tag_ff    <= emit_tag;
         rsp_run_ff    <= 4'(run_cnt_in);
         rsp_q_ff      <= 5'(fill_in);
         rsp_last_ff   <= emit_last;
      end
   end

   // wait queue: head in cell 0, shifts toward the head on pop
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
      cell_ctl_type  ctl;
      logic [TW-1:0] nb;
      assign ctl.shift = q_pop;
      assign ctl.load  = q_push && (push_pos == QW'(i));
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign nb = q_tag[i];
      end else begin : g_mid
         assign nb = q_tag[i+1];
      end
      dtqd_queue_cell #(.TW(TW)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (QW'(i) < fill_ff),
         .key       (key_ff),
         .load_data (key_ff),
         .next_tag  (nb),
         .tag_out   (q_tag[i]),
         .match_out (q_match[i])
      );
   end

   // running set: packed from slot 0, closes up on removal
   assign r_hit[0] = 1'b0;
   for (genvar j = 0; j < RUN_SLOTS; j++) begin : g_run
      cell_ctl_type  ctl;
      logic [TW-1:0] nb;
      assign ctl.shift = r_rm;
      assign ctl.load  = r_ins && (run_cnt_ff == CW'(j));
      if (j == RUN_SLOTS - 1) begin : g_end
         assign nb = r_tag[j];
      end else begin : g_mid
         assign nb = r_tag[j+1];
      end
      dtqd_run_cell #(.TW(TW)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (CW'(j) < run_cnt_ff),
         .key       (key_ff),
         .load_data (key_ff),
         .next_tag  (nb),
         .hit_in    (r_hit[j]),
         .tag_out   (r_tag[j]),
         .hit_out   (r_hit[j+1])
      );
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_tag    = 16'(rsp_tag_ff);
   assign rsp_running_count = rsp_run_ff;
   assign rsp_queued_count  = rsp_q_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== hw/rtl/dtqd_queue_cell.sv =====
module dtqd_queue_cell
   import dtqd_pkg::*;
#(
   parameter int TW = 16
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic          occupied,
   input  logic [TW-1:0] key,
   input  logic [TW-1:0] load_data,
   input  logic [TW-1:0] next_tag,
   output logic [TW-1:0] tag_out,
   output logic          match_out
);

   logic [TW-1:0] tag_ff;
   logic [TW-1:0] tag_in;
   logic          match_ff;
   logic          match_in;

   always_comb begin
      tag_in = tag_ff;
      if (ctl.load) begin
         tag_in = load_data;
      end else if (ctl.shift) begin
         tag_in = next_tag;
      end
      match_in = occupied && (tag_ff == key);
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      match_ff <= match_in;
   end

   assign tag_out   = tag_ff;
   assign match_out = match_ff;

endmodule

// ===== hw/rtl/dtqd_run_cell.sv =====
module dtqd_run_cell
   import dtqd_pkg::*;
#(
   parameter int TW = 16
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic          occupied,
   input  logic [TW-1:0] key,
   input  logic [TW-1:0] load_data,
   input  logic [TW-1:0] next_tag,
   input  logic          hit_in,
   output logic [TW-1:0] tag_out,
   output logic          hit_out
);

   logic [TW-1:0] tag_ff;
   logic [TW-1:0] tag_in;
   logic          match_ff;
   logic          match_in;

   // hit_out: a match at this slot or below; slots from the match upward close the gap
   assign hit_out = hit_in | match_ff;

   always_comb begin
      tag_in = tag_ff;
      if (ctl.load) begin
         tag_in = load_data;
      end else if (ctl.shift && hit_out) begin
         tag_in = next_tag;
      end
      match_in = occupied && (tag_ff == key);
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      match_ff <= match_in;
   end

   assign tag_out = tag_ff;

endmodule

// ===== test/dtqd_checker.sv =====
module dtqd_checker
   import dtqd_pkg::*;
#(
   parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_task_tag,
   input  logic [3:0]  req_pool_accepts,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_status,
   input  logic [15:0] rsp_result_tag,
   input  logic [3:0]  rsp_running_count,
   input  logic [4:0]  rsp_queued_count,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          outstanding,
   output int          compared
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = 16;
   localparam int SLOTS  = 8;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] tag;
      logic [3:0]  running;
      logic [4:0]  queued;
      logic        last;
   } task_result_type;

   task_result_type expected_results[$];

   logic [15:0] wait_tags [QDEPTH];
   logic [3:0]  head_idx;
   logic [3:0]  tail_idx;
   logic [4:0]  fill;
   logic [15:0] run_tags [SLOTS];
   logic        run_used [SLOTS];
   logic [3:0]  run_limit;
   int          errs;
   int          seen;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      compared    = 0;
      errs        = 0;
      seen        = 0;
   end

   function automatic int busy_slots();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
         if (run_used[i]) n++;
      return n;
   endfunction

   function automatic int slot_of(logic [15:0] t);
      int hit;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && run_used[i] && run_tags[i] == t) hit = i;
      return hit;
   endfunction

   function automatic bit queue_has(logic [15:0] t);
      logic [3:0] idx;
      bit found;
      idx = head_idx;
      found = 1'b0;
      for (int k = 0; k < fill; k++) begin
         if (wait_tags[idx] == t) found = 1'b1;
         idx = idx + 1'b1;
      end
      return found;
   endfunction

   task automatic enqueue(logic [15:0] t);
      wait_tags[tail_idx] = t;
      tail_idx = tail_idx + 1'b1;
      fill = fill + 1'b1;
   endtask

   task automatic post(logic [3:0] st, logic [15:0] t);
      task_result_type r;
      r.status  = st;
      r.tag     = t;
      r.running = 4'(busy_slots());
      r.queued  = fill;
      r.last    = 1'b0;
      expected_results.push_back(r);
   endtask

   task automatic schedule_request(req_kind_type kind, logic [15:0] t, logic [3:0] accepts);
      int first;
      int cap;
      int sent;
      int free;
      bit stop;
      logic [15:0] h;
      first = expected_results.size();
      case (kind)
         REQ_ADD: begin
            if (queue_has(t))
               post(ST_DUPLICATE, t);
            else if (fill >= QDEPTH)
               post(ST_OVERFLOW, t);
            else begin
               enqueue(t);
               post(ST_QUEUED, t);
            end
         end
         REQ_TICK: begin
            cap = (run_limit > SLOTS) ? SLOTS : int'(run_limit);
            if (busy_slots() >= cap)
               post(ST_LIMIT, '0);
            else begin
               sent = 0;
               stop = 1'b0;
               while (!stop && busy_slots() < cap) begin
                  if (fill == 0) begin
                     post(ST_EMPTY, '0);
                     stop = 1'b1;
                  end else begin
                     h = wait_tags[head_idx];
                     head_idx = head_idx + 1'b1;
                     fill = fill - 1'b1;
                     if (slot_of(h) >= 0) begin
                        enqueue(h);
                        post(ST_HEAD_BUSY, h);
                        stop = 1'b1;
                     end else if (sent >= accepts) begin
                        enqueue(h);
                        post(ST_POOL_REFUSED, h);
                        stop = 1'b1;
                     end else begin
                        free = -1;
                        for (int j = 0; j < SLOTS; j++)
                           if (free < 0 && !run_used[j]) free = j;
                        run_used[free] = 1'b1;
                        run_tags[free] = h;
                        sent++;
                        post(ST_DISPATCHED, h);
                     end
                  end
               end
            end
         end
         REQ_DONE: begin
            free = slot_of(t);
            if (free >= 0) begin
               run_used[free] = 1'b0;
               post(ST_REMOVED, t);
            end else
               post(ST_UNKNOWN, t);
         end
         default: ;
      endcase
      if (expected_results.size() > first)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      task_result_type want;
      task_result_type got;
      if (reset) begin
         expected_results.delete();
         head_idx  = '0;
         tail_idx  = '0;
         fill      = '0;
         run_limit = MAX_RUN_RESET;
         for (int i = 0; i < SLOTS; i++) run_used[i] = 1'b0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_result_tag, rsp_running_count, rsp_queued_count, rsp_last};
            if (expected_results.size() == 0) begin
               if (errs < 10)
                  $display("%0t unexpected result: status %0d tag %h run %0d queued %0d last %0d",
                           $realtime, got.status, got.tag, got.running, got.queued, got.last);
               errs++;
            end else begin
               want = expected_results.pop_front();
               seen++;
               if (got !== want) begin
                  if (errs < 10)
                     $display({"%0t mismatch: expected status %0d tag %h run %0d queued %0d ",
                               "last %0d, got status %0d tag %h run %0d queued %0d last %0d"},
                              $realtime, want.status, want.tag, want.running, want.queued,
                              want.last, got.status, got.tag, got.running, got.queued,
                              got.last);
                  errs++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
            run_limit = pwdata[3:0];
         if (start && !busy)
            schedule_request(req_kind_type'(req_type), req_task_tag, req_pool_accepts);
      end
      mismatches  <= errs;
      outstanding <= expected_results.size();
      compared    <= seen;
   end

endmodule

// ===== test/tb.sv =====
module tb
   import dtqd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] LIMIT_ADDR  = 3'd0;
   localparam int         STALL_LIMIT = 2000;
   localparam int         POOL_SIZE   = 20;
   localparam int         PHASES      = 7;

   logic        clock;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic [1:0]  req_type         = REQ_NONE;
   logic [15:0] req_task_tag     = '0;
   logic [3:0]  req_pool_accepts = '0;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [2:0]  paddr            = '0;
   logic [31:0] pwdata           = '0;
   wire         busy;
   wire         rsp_valid;
   wire  [3:0]  rsp_status;
   wire  [15:0] rsp_result_tag;
   wire  [3:0]  rsp_running_count;
   wire  [4:0]  rsp_queued_count;
   wire         rsp_last;
   wire  [31:0] prdata;
   wire         pready;

   int          mismatches;
   int          outstanding;
   int          compared;
   int          stall = 0;
   int          requests = 0;
   logic [15:0] tag_pool [POOL_SIZE];
   int          phase_limit [PHASES] = '{5, 1, 8, 0, 15, 3, 4};

   dedup_task_queue_dispatcher dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_task_tag      (req_task_tag),
      .req_pool_accepts  (req_pool_accepts),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_tag    (rsp_result_tag),
      .rsp_running_count (rsp_running_count),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   dtqd_checker #(.LIMIT_ADDR(LIMIT_ADDR)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_task_tag      (req_task_tag),
      .req_pool_accepts  (req_pool_accepts),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_tag    (rsp_result_tag),
      .rsp_running_count (rsp_running_count),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .compared          (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall <= 0;
      else
         stall <= stall + 1;
   end

   initial begin
      while (stall < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
   end

   task automatic issue(req_kind_type kind, logic [15:0] t, logic [3:0] accepts);
      start            <= 1'b1;
      req_type         <= kind;
      req_task_tag     <= t;
      req_pool_accepts <= accepts;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind != REQ_NONE) requests++;
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait for every expected result with start held low, then idle before returning
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [3:0] value);
      logic [31:0] w;
      w = $urandom;
      w[3:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= w;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [15:0] pick_tag();
      int s;
      s = $urandom_range(0, 99);
      if (s < 85) return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (s < 90) return (s < 88) ? 16'h0000 : 16'hffff;
      return 16'($urandom);
   endfunction

   task automatic random_requests(int count, bit idling, bit mid_drain);
      int sent;
      int r;
      req_kind_type kind;
      logic [3:0] accepts;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 45)      kind = REQ_ADD;
         else if (r < 70) kind = REQ_TICK;
         else if (r < 95) kind = REQ_DONE;
         else             kind = REQ_NONE;
         accepts = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
         issue(kind, pick_tag(), accepts);
         if (kind != REQ_NONE) sent++;
         if (mid_drain && sent == count / 2)
            drain();
         else if (idling && $urandom_range(0, 99) < 32)
            hold_off($urandom_range(1, 8));
      end
   endtask

   initial begin
      foreach (tag_pool[i]) tag_pool[i] = 16'($urandom);
      phase_limit[PHASES - 1] = $urandom_range(2, 7);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(REQ_TICK, 16'h0000, 4'd3);
      issue(REQ_DONE, 16'h1234, 4'd0);
      issue(REQ_ADD,  16'h0000, 4'd0);
      issue(REQ_ADD,  16'hffff, 4'd15);
      issue(REQ_ADD,  16'hffff, 4'd0);
      issue(REQ_ADD,  16'h5a5a, 4'd0);
      issue(REQ_TICK, 16'h0000, 4'd0);
      hold_off(3);
      issue(REQ_TICK, 16'hffff, 4'd15);
      issue(REQ_ADD,  16'h0000, 4'd0);
      issue(REQ_TICK, 16'h0000, 4'd8);
      issue(REQ_DONE, 16'h0000, 4'd0);
      issue(REQ_DONE, 16'h0000, 4'd0);
      issue(REQ_ADD,  16'h8001, 4'd0);
      issue(REQ_ADD,  16'h7ffe, 4'd0);
      issue(REQ_TICK, 16'h0000, 4'd1);
      issue(REQ_TICK, 16'h0000, 4'd8);
      issue(REQ_TICK, 16'h0000, 4'd8);
      issue(REQ_NONE, 16'hffff, 4'd15);
      issue(REQ_DONE, 16'hffff, 4'd0);
      issue(REQ_DONE, 16'h5a5a, 4'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            write_limit(4'(phase_limit[ph]));
         end
         random_requests(50, ph != 2, ph == 4);
      end
      drain();

      $display("%0d requests over %0d max_running settings (0 and 15 among them),",
               requests, PHASES);
      $display("%0d results compared", compared);
      if (outstanding != 0)
         $display("%0d expected results never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
